[rtl/rgbhsl_pkg.sv]
// Shared types and constants for the RGB to HSL converter.
package rgbhsl_pkg;

  // Which channel holds the maximum; ties resolve red, then green.
  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_ch_e;

  localparam int CH_W     = 8;
  localparam int SUM_W    = 9;
  localparam int DIV_W    = 9;    // divisors are 2*delta or 2*den, at most 510
  localparam int T_W      = 18;   // signed hue*delta before wrap
  localparam int TW_W     = 17;   // unsigned hue*delta after wrap, below 360*255

  localparam int DEG_60   = 60;
  localparam int DEG_120  = 120;
  localparam int DEG_240  = 240;
  localparam int DEG_360  = 360;
  localparam int CH_FULL  = 255;
  localparam int SUM_FULL = 510;

endpackage

[rtl/rgb_to_hsl_convert.sv]
// RGB to HSL converter: three front stages, a bit-per-stage divider pair, output register.
// Each divider stage resolves one quotient bit.
// Throughput: one transaction per cycle; a stall at the output freezes the whole pipeline.
// Reset: rst_ni is asynchronous, active low, and clears every stage valid bit; data
//   registers are not reset.
module rgb_to_hsl_convert #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [9+HUE_FRAC_BITS-1:0] hue_o,
  output logic [SAT_FRAC_BITS:0]     saturation_o,
  output logic [8:0]                 lightness_sum_o
);

  localparam int HW  = 9 + HUE_FRAC_BITS;
  localparam int SW  = SAT_FRAC_BITS + 1;
  localparam int D   = (HW > SW) ? HW : SW;          // quotient bits per divider
  localparam int NW  = D + rgbhsl_pkg::DIV_W;        // numerator width
  localparam int RW  = rgbhsl_pkg::DIV_W;
  localparam int TW  = rgbhsl_pkg::TW_W;
  localparam int T_W = rgbhsl_pkg::T_W;
  localparam logic [D-1:0] HUE_FULL = D'(rgbhsl_pkg::DEG_360) << HUE_FRAC_BITS;

  // global advance: the pipeline moves when the output slot is free or being taken
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage 1: max, min, channel select ----------------
  logic                    s1_vld_q;
  logic [7:0]              s1_delta_q, s1_delta_d;
  logic [8:0]              s1_sum_q, s1_sum_d;
  logic signed [8:0]       s1_diff_q, s1_diff_d;
  rgbhsl_pkg::max_ch_e     s1_sel_q, s1_sel_d;

  always_comb begin
    logic [7:0] mx, mn;
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    s1_delta_d = mx - mn;
    s1_sum_d   = {1'b0, mx} + {1'b0, mn};
    if (red_i == mx) begin
      s1_sel_d  = rgbhsl_pkg::MAX_RED;
      s1_diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == mx) begin
      s1_sel_d  = rgbhsl_pkg::MAX_GREEN;
      s1_diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      s1_sel_d  = rgbhsl_pkg::MAX_BLUE;
      s1_diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  // ---------------- stage 2: hue times delta ----------------
  logic                  s2_vld_q;
  logic [7:0]            s2_delta_q;
  logic [8:0]            s2_sum_q;
  logic signed [T_W-1:0] s2_t_q, s2_t_d;

  always_comb begin
    logic [T_W-1:0] base;
    logic signed [T_W-1:0] dext;
    unique case (s1_sel_q)
      rgbhsl_pkg::MAX_RED:   base = '0;
      rgbhsl_pkg::MAX_GREEN: base = T_W'(s1_delta_q) * T_W'(rgbhsl_pkg::DEG_120);
      rgbhsl_pkg::MAX_BLUE:  base = T_W'(s1_delta_q) * T_W'(rgbhsl_pkg::DEG_240);
      default:               base = '0;
    endcase
    dext   = $signed({{(T_W-9){s1_diff_q[8]}}, s1_diff_q});
    s2_t_d = $signed(base) + dext * $signed(T_W'(rgbhsl_pkg::DEG_60));
  end

  // ---------------- stage 3: wrap, numerators, divisors ----------------
  logic [NW-1:0]  s3_hn_d, s3_sn_d;
  logic [RW-1:0]  s3_hd_d, s3_sd_d;

  always_comb begin
    logic signed [T_W-1:0] tw;
    logic [7:0]            den;
    logic [8:0]            den_hi;
    if (s2_t_q < 0) begin
      tw = s2_t_q + $signed(T_W'(s2_delta_q) * T_W'(rgbhsl_pkg::DEG_360));
    end else begin
      tw = s2_t_q;
    end
    den_hi = 9'(rgbhsl_pkg::SUM_FULL) - s2_sum_q;
    den    = (s2_sum_q <= 9'(rgbhsl_pkg::CH_FULL)) ? s2_sum_q[7:0] : den_hi[7:0];
    s3_hn_d = (NW'(tw[TW-1:0]) << (HUE_FRAC_BITS + 1)) + NW'(s2_delta_q);
    s3_hd_d = {1'b0, s2_delta_q} << 1;
    s3_sn_d = (NW'(s2_delta_q) << (SAT_FRAC_BITS + 1)) + NW'(den);
    s3_sd_d = {1'b0, den} << 1;
  end

  // ---------------- divider stages ----------------
  // index 0 holds the stage-3 result; index k holds k resolved quotient bits;
  // dv_q[k] is the valid bit of index k
  logic [D:0]    dv_q;
  logic [RW-1:0] h_rem_q [0:D];
  logic [D-1:0]  h_num_q [0:D];
  logic [D-1:0]  h_quo_q [0:D];
  logic [RW-1:0] h_div_q [0:D];
  logic [RW-1:0] s_rem_q [0:D];
  logic [D-1:0]  s_num_q [0:D];
  logic [D-1:0]  s_quo_q [0:D];
  logic [RW-1:0] s_div_q [0:D];
  logic          grey_q  [0:D];
  logic [8:0]    sum_q   [0:D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      dv_q     <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      dv_q        <= {dv_q[D-1:0], s2_vld_q};
      out_valid_o <= dv_q[D];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_delta_q <= s1_delta_d;
      s1_sum_q   <= s1_sum_d;
      s1_diff_q  <= s1_diff_d;
      s1_sel_q   <= s1_sel_d;
      s2_delta_q <= s1_delta_q;
      s2_sum_q   <= s1_sum_q;
      s2_t_q     <= s2_t_d;
      h_rem_q[0] <= s3_hn_d[NW-1:D];
      h_num_q[0] <= s3_hn_d[D-1:0];
      h_quo_q[0] <= '0;
      h_div_q[0] <= s3_hd_d;
      s_rem_q[0] <= s3_sn_d[NW-1:D];
      s_num_q[0] <= s3_sn_d[D-1:0];
      s_quo_q[0] <= '0;
      s_div_q[0] <= s3_sd_d;
      grey_q[0]  <= (s2_delta_q == '0);
      sum_q[0]   <= s2_sum_q;
    end
  end

  for (genvar k = 1; k <= D; k++) begin : g_div
    logic [RW:0] h_trial, s_trial, h_diff, s_diff;
    logic        h_bit, s_bit;
    always_comb begin
      h_trial = {h_rem_q[k-1], h_num_q[k-1][D-1]};
      s_trial = {s_rem_q[k-1], s_num_q[k-1][D-1]};
      h_diff  = h_trial - {1'b0, h_div_q[k-1]};
      s_diff  = s_trial - {1'b0, s_div_q[k-1]};
      h_bit   = (h_trial >= {1'b0, h_div_q[k-1]});
      s_bit   = (s_trial >= {1'b0, s_div_q[k-1]});
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        h_rem_q[k] <= h_bit ? h_diff[RW-1:0] : h_trial[RW-1:0];
        s_rem_q[k] <= s_bit ? s_diff[RW-1:0] : s_trial[RW-1:0];
        h_num_q[k] <= h_num_q[k-1] << 1;
        s_num_q[k] <= s_num_q[k-1] << 1;
        h_quo_q[k] <= {h_quo_q[k-1][D-2:0], h_bit};
        s_quo_q[k] <= {s_quo_q[k-1][D-2:0], s_bit};
        h_div_q[k] <= h_div_q[k-1];
        s_div_q[k] <= s_div_q[k-1];
        grey_q[k]  <= grey_q[k-1];
        sum_q[k]   <= sum_q[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      // grey pixels and hues that round up to a full turn give zero
      if (grey_q[D] || (h_quo_q[D] >= HUE_FULL)) begin
        hue_o <= '0;
      end else begin
        hue_o <= h_quo_q[D][HW-1:0];
      end
      saturation_o    <= grey_q[D] ? '0 : s_quo_q[D][SW-1:0];
      lightness_sum_o <= sum_q[D];
    end
  end

  // ---------------- assertions ----------------
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (D'(hue_o) < HUE_FULL))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (saturation_o <= (SW'(1) << SAT_FRAC_BITS)))
    else $error("saturation above one");

  a_hue_implies_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (hue_o != '0)) |-> (saturation_o != '0))
    else $error("colored pixel with zero saturation");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[D] && !grey_q[D]) |-> ((h_rem_q[D] < h_div_q[D]) && (s_rem_q[D] < s_div_q[D])))
    else $error("divider remainder not below divisor");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(dv_q) && $stable(s2_vld_q)))
    else $error("pipeline moved during stall");

endmodule

[tb/tb_rgb_to_hsl_convert.sv]
// Self-checking testbench for rgb_to_hsl_convert: directed table, random pixels, predictor.
module tb_rgb_to_hsl_convert;

  localparam int HUE_FB      = 6;
  localparam int SAT_FB      = 15;
  localparam int HUE_W       = 9 + HUE_FB;
  localparam int SAT_W       = SAT_FB + 1;
  localparam int RAND_PIXELS = 500;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [8:0]       lsum;
  } hsl_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       typed;   // expected value written into the row
    hsl_t       want;
  } pixel_row_t;

  localparam int N_ROWS = 25;

  pixel_row_t directed_rows [N_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd0,     9'd0}},    // black
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     16'd0,     9'd510}},  // white
    '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     16'd0,     9'd256}},  // mid grey
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     16'd32768, 9'd255}},  // red
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  16'd32768, 9'd255}},  // green
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 16'd32768, 9'd255}},  // blue
    '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  16'd32768, 9'd255}},  // red/green tie
    '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 16'd32768, 9'd255}},  // green/blue tie
    '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 16'd32768, 9'd255}},  // red/blue tie
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},  // negative hue wrap, just under 360
    '{8'd255, 8'd1,   8'd0,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},  // delta of one, dark
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},  // delta of one, bright
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd254, 8'd255, 8'd255, 1'b0, '0},
    '{8'd200, 8'd100, 8'd50,  1'b0, '0},
    '{8'd50,  8'd200, 8'd100, 1'b0, '0},
    '{8'd100, 8'd50,  8'd200, 1'b0, '0},
    '{8'd10,  8'd20,  8'd30,  1'b0, '0},
    '{8'd255, 8'd128, 8'd0,   1'b0, '0},
    '{8'd170, 8'd85,  8'd85,  1'b0, '0},
    '{8'd127, 8'd128, 8'd128, 1'b0, '0},  // sum at 255, both divisor branches meet
    '{8'd128, 8'd127, 8'd127, 1'b0, '0},
    '{8'd129, 8'd128, 8'd128, 1'b0, '0},
    '{8'd1,   8'd2,   8'd3,   1'b0, '0}
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [7:0]       red_i       = '0;
  logic [7:0]       green_i     = '0;
  logic [7:0]       blue_i      = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [HUE_W-1:0] hue_o;
  logic [SAT_W-1:0] saturation_o;
  logic [8:0]       lightness_sum_o;

  // typed expectation travels with the payload
  logic             pix_typed   = 1'b0;
  hsl_t             pix_want    = '0;

  hsl_t hsl_expected_q [$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   out_stall_left = 0;
  bit   burst_mode     = 1'b0;

  rgb_to_hsl_convert #(
    .HUE_FRAC_BITS(HUE_FB),
    .SAT_FRAC_BITS(SAT_FB)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hue_o          (hue_o),
    .saturation_o   (saturation_o),
    .lightness_sum_o(lightness_sum_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic hsl_t predict_hsl(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int                  hi, lo, delta, sum, den;
    longint              t;
    longint              q;
    rgbhsl_pkg::max_ch_e which;
    hsl_t                res;
    hi = r; lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    sum   = hi + lo;
    res   = '0;
    res.lsum = sum[8:0];
    if (delta != 0) begin
      if (r == hi) which = rgbhsl_pkg::MAX_RED;
      else if (g == hi) which = rgbhsl_pkg::MAX_GREEN;
      else which = rgbhsl_pkg::MAX_BLUE;
      case (which)
        rgbhsl_pkg::MAX_RED:
          t = rgbhsl_pkg::DEG_60 * (int'(g) - int'(b));
        rgbhsl_pkg::MAX_GREEN:
          t = rgbhsl_pkg::DEG_120 * delta + rgbhsl_pkg::DEG_60 * (int'(b) - int'(r));
        default:
          t = rgbhsl_pkg::DEG_240 * delta + rgbhsl_pkg::DEG_60 * (int'(r) - int'(g));
      endcase
      if (t < 0) t += rgbhsl_pkg::DEG_360 * delta;
      // round half up: (2*t*2^F + delta) / (2*delta)
      q = ((t <<< (HUE_FB + 1)) + delta) / (2 * delta);
      if (q >= (longint'(rgbhsl_pkg::DEG_360) <<< HUE_FB)) q = 0;
      res.hue = q[HUE_W-1:0];
      den = (sum <= rgbhsl_pkg::CH_FULL) ? sum : (rgbhsl_pkg::SUM_FULL - sum);
      q = ((longint'(delta) <<< (SAT_FB + 1)) + den) / (2 * den);
      res.sat = q[SAT_W-1:0];
    end
    return res;
  endfunction

  function automatic int pixel_gap();
    int x;
    x = $urandom_range(0, 99);
    if (burst_mode || x < 60) return 0;
    if (x < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] near_value(int base);
    int v;
    v = base + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic make_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    int mode, base;
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    if (mode < 5) begin
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
    end else if (mode < 7) begin
      // near grey: tiny delta
      r = near_value(base);
      g = near_value(base);
      b = near_value(base);
    end else if (mode < 9) begin
      r = extreme_value();
      g = extreme_value();
      b = extreme_value();
    end else begin
      // forced tie between two channels
      r = 8'(base);
      g = 8'($urandom_range(0, 255));
      b = $urandom_range(0, 1) ? r : g;
    end
  endtask

  // Returns at the edge where the transaction is accepted.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic typed, hsl_t want);
    int gap;
    gap = pixel_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    pix_typed  <= typed;
    pix_want   <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (hsl_expected_q.size() == 0);
  endtask

  task automatic note_failure(string what, hsl_t want, hsl_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s: expected hue=%0d sat=%0d lsum=%0d, got hue=%0d sat=%0d lsum=%0d",
               what, want.hue, want.sat, want.lsum, got.hue, got.sat, got.lsum);
  endtask

  // output side back-pressure
  always @(posedge clk_i) begin
    if (out_stall_left > 0) begin
      out_ready_i    <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (rst_ni && !burst_mode && $urandom_range(0, 5) == 0) begin
      out_ready_i    <= 1'b0;
      out_stall_left <= pixel_gap();
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    hsl_t got, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        hsl_expected_q.push_back(pix_typed ? pix_want : predict_hsl(red_i, green_i, blue_i));
      if (out_valid_o && out_ready_i) begin
        got = '{hue_o, saturation_o, lightness_sum_o};
        if (hsl_expected_q.size() == 0) begin
          note_failure("unexpected transaction", '0, got);
        end else begin
          want = hsl_expected_q.pop_front();
          if (got !== want) note_failure("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] r, g, b;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                 directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    for (int n = 0; n < RAND_PIXELS; n++) begin
      burst_mode = (n >= 200 && n < 260);
      if (n == 350) drain_results();
      make_pixel(r, g, b);
      send_pixel(r, g, b, 1'b0, '0);
    end
    burst_mode = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && hsl_expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
